>>> hdl/tsvt_pkg.sv
// Package for the TSV record tokenizer: payload structs, tokenizer state,
// byte and result codes, and the per-byte tokenizer step functions.
// No dependencies.
`timescale 1ns / 1ps

package tsvt_pkg;

    // Fields a line may start before overflow is reported
    localparam int FIELD_LIMIT = 16;
    localparam int FIELD_CNT_W = $clog2(FIELD_LIMIT + 1);

    // Result bundle queue depth (power of two)
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Most results one byte can cause
    localparam int MAX_RES = 3;
    localparam int RCNT_W  = $clog2(MAX_RES + 1);

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    localparam logic [2:0] K_TYPE     = 3'd0;
    localparam logic [2:0] K_FIELD    = 3'd1;
    localparam logic [2:0] K_KEY      = 3'd2;
    localparam logic [2:0] K_VALUE    = 3'd3;
    localparam logic [2:0] K_END      = 3'd4;
    localparam logic [2:0] K_OVERFLOW = 3'd5;

    typedef enum logic [2:0] {
        PH_SKIP    = 3'd0,
        PH_COMMENT = 3'd1,
        PH_TYPE    = 3'd2,
        PH_KEY     = 3'd3,
        PH_VALUE   = 3'd4,
        PH_DEAD    = 3'd5
    } t_phase;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_buffer;
    } t_in_item;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data_byte;
        logic       last_of_run;
    } t_out_item;

    typedef struct packed {
        t_phase                 phase;
        logic                   carriage_held;
        logic [FIELD_CNT_W-1:0] field_count;
        logic                   token_first_byte;
        logic                   key_is_whole;
    } t_tok_state;

    // One tokenizer step: new state and at most one result
    typedef struct packed {
        t_tok_state st;
        logic       emit;
        t_out_item  item;
    } t_step;

    // Results of one input byte, in order, item 0 first
    typedef struct packed {
        logic [RCNT_W-1:0]         count;
        t_out_item [MAX_RES-1:0]   items;
    } t_bundle;

    function automatic t_tok_state tok_reset_state();
        t_tok_state s;
        s.phase            = PH_SKIP;
        s.carriage_held    = 1'b0;
        s.field_count      = '0;
        s.token_first_byte = 1'b0;
        s.key_is_whole     = 1'b0;
        return s;
    endfunction

    function automatic t_out_item tok_item(input logic [2:0] kind, input logic [7:0] data);
        t_out_item it;
        it.kind        = kind;
        it.data_byte   = data;
        it.last_of_run = 1'b0;
        return it;
    endfunction

    function automatic t_step tok_record_end(input t_tok_state s);
        t_step r;
        r.st                  = s;
        r.st.phase            = PH_SKIP;
        r.st.field_count      = '0;
        r.st.token_first_byte = 1'b0;
        r.st.key_is_whole     = 1'b0;
        r.emit                = 1'b1;
        r.item                = tok_item(K_END, 8'h00);
        return r;
    endfunction

    function automatic t_step tok_field_start(input t_tok_state s);
        t_step r;
        r.st   = s;
        r.emit = 1'b1;
        if (s.field_count >= FIELD_CNT_W'(FIELD_LIMIT)) begin
            r.item     = tok_item(K_OVERFLOW, 8'h00);
            r.st.phase = PH_DEAD;
        end else begin
            r.item                = tok_item(K_FIELD, 8'h00);
            r.st.field_count      = s.field_count + FIELD_CNT_W'(1);
            r.st.phase            = PH_KEY;
            r.st.token_first_byte = 1'b1;
            r.st.key_is_whole     = 1'b0;
        end
        return r;
    endfunction

    function automatic t_step tok_handle(input t_tok_state s, input logic [7:0] b);
        t_step r;
        logic  key_out;
        r       = '0;
        r.st    = s;
        key_out = 1'b1;
        case (s.phase)
            PH_SKIP: begin
                if (b == CH_SPACE || b == CH_TAB || b == CH_LF) begin
                    r.emit = 1'b0;
                end else if (b == CH_HASH) begin
                    r.st.phase = PH_COMMENT;
                end else begin
                    r.st.phase = PH_TYPE;
                    r.emit     = 1'b1;
                    r.item     = tok_item(K_TYPE, b);
                end
            end
            PH_COMMENT: begin
                if (b == CH_LF) begin
                    r.st.phase = PH_SKIP;
                end
            end
            PH_TYPE, PH_VALUE: begin
                if (b == CH_TAB) begin
                    r = tok_field_start(s);
                end else if (b == CH_LF) begin
                    r = tok_record_end(s);
                end else begin
                    r.emit = 1'b1;
                    r.item = tok_item((s.phase == PH_TYPE) ? K_TYPE : K_VALUE, b);
                end
            end
            PH_KEY: begin
                if (b == CH_TAB) begin
                    r = tok_field_start(s);
                end else if (b == CH_LF) begin
                    r = tok_record_end(s);
                end else begin
                    if (b == CH_EQ) begin
                        if (s.token_first_byte) begin
                            r.st.key_is_whole = 1'b1;
                        end else if (!s.key_is_whole) begin
                            r.st.phase = PH_VALUE;
                            key_out    = 1'b0;
                        end
                    end
                    if (key_out) begin
                        r.st.token_first_byte = 1'b0;
                        r.emit                = 1'b1;
                        r.item                = tok_item(K_KEY, b);
                    end
                end
            end
            default: begin
                r.emit = 1'b0;
            end
        endcase
        return r;
    endfunction

    // A carriage return is held back in every phase but comment and dead
    function automatic logic tok_holds_cr(input t_tok_state s);
        return s.phase == PH_SKIP || s.phase == PH_TYPE || s.phase == PH_KEY ||
               s.phase == PH_VALUE;
    endfunction

endpackage

>>> hdl/tsv_record_tokenizer.sv
// TSV record tokenizer top level: front end, bundle queue, back end.
// Depends on tsvt_pkg, tsvt_front, tsvt_queue, tsvt_back.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one text byte
// per transfer with an end-of-buffer flag. Output channel (o_out_valid /
// i_out_ready / o_out_data) gives tagged results: type, field start, key,
// value, record end or field overflow, with last_of_run on the final
// result caused by a byte. A byte may cause zero to three results.
// A byte's results go through the bundle queue into the output register.
// Throughput: one byte per cycle while bytes cause at most one result each
// and i_out_ready stays high; the output side moves one result per cycle
// while ready; results per byte against the one output register set the rate.
// A four-bundle queue decouples the two sides; when the receiver stalls,
// the queue fills and o_in_ready drops, and the front resumes as soon as
// a bundle retires.
// Reset (synchronous, active low) returns the tokenizer to line start,
// empties the queue and drops any pending output.
`timescale 1ns / 1ps

module tsv_record_tokenizer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tsvt_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tsvt_pkg::t_out_item o_out_data
);

    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_empty;
    tsvt_pkg::t_bundle push_bundle;
    tsvt_pkg::t_bundle head_bundle;

    tsvt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_bundle   (push_bundle)
    );

    tsvt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_bundle),
        .i_pop   (pop),
        .o_head  (head_bundle),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    tsvt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_bundle),
        .i_empty     (q_empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

>>> hdl/tsvt_front.sv
// Front end of the TSV tokenizer: accepts bytes, runs the tokenizer state
// and packs each byte's results into one bundle. Depends on tsvt_pkg.
`timescale 1ns / 1ps

module tsvt_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tsvt_pkg::t_in_item i_in_data,
    input  logic               i_q_full,
    output logic               o_push,
    output tsvt_pkg::t_bundle  o_bundle
);

    tsvt_pkg::t_tok_state                            r_state;
    tsvt_pkg::t_tok_state                            n_state;
    tsvt_pkg::t_step                                 step;
    tsvt_pkg::t_out_item [tsvt_pkg::MAX_RES-1:0]     res;
    logic [tsvt_pkg::RCNT_W-1:0]                     cnt;
    logic [7:0]                                      b;
    logic                                            eob;
    logic                                            accept;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign b          = i_in_data.byte_in;
    assign eob        = i_in_data.end_of_buffer;

    always_comb begin
        n_state = r_state;
        res     = '0;
        cnt     = '0;
        step    = '0;

        // release or drop a held carriage return
        if (n_state.carriage_held) begin
            n_state.carriage_held = 1'b0;
            if (b != tsvt_pkg::CH_LF) begin
                step    = tsvt_pkg::tok_handle(n_state, tsvt_pkg::CH_CR);
                n_state = step.st;
                if (step.emit) begin
                    res[cnt] = step.item;
                    cnt      = cnt + tsvt_pkg::RCNT_W'(1);
                end
            end
        end

        if (b == tsvt_pkg::CH_CR && tsvt_pkg::tok_holds_cr(n_state)) begin
            if (!eob) begin
                n_state.carriage_held = 1'b1;
            end
        end else begin
            step    = tsvt_pkg::tok_handle(n_state, b);
            n_state = step.st;
            if (step.emit) begin
                res[cnt] = step.item;
                cnt      = cnt + tsvt_pkg::RCNT_W'(1);
            end
        end

        // close an open record, then start the next buffer clean
        if (eob) begin
            if (n_state.phase == tsvt_pkg::PH_TYPE || n_state.phase == tsvt_pkg::PH_KEY ||
                n_state.phase == tsvt_pkg::PH_VALUE) begin
                step     = tsvt_pkg::tok_record_end(n_state);
                res[cnt] = step.item;
                cnt      = cnt + tsvt_pkg::RCNT_W'(1);
            end
            n_state = tsvt_pkg::tok_reset_state();
        end

        for (int i = 0; i < tsvt_pkg::MAX_RES; i++) begin
            res[i].last_of_run = (tsvt_pkg::RCNT_W'(i) == cnt - tsvt_pkg::RCNT_W'(1));
        end
    end

    assign o_push         = accept && (cnt != '0);
    assign o_bundle.count = cnt;
    assign o_bundle.items = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsvt_pkg::tok_reset_state();
        end else if (accept) begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_dead_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == tsvt_pkg::PH_DEAD |->
            r_state.field_count == tsvt_pkg::FIELD_CNT_W'(tsvt_pkg::FIELD_LIMIT))
        else $error("dead phase without full field count");
    a_cr_held_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.carriage_held |-> (r_state.phase == tsvt_pkg::PH_SKIP ||
            r_state.phase == tsvt_pkg::PH_TYPE || r_state.phase == tsvt_pkg::PH_KEY ||
            r_state.phase == tsvt_pkg::PH_VALUE))
        else $error("carriage return held in comment or dead phase");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_q_full && o_bundle.count <= tsvt_pkg::RCNT_W'(tsvt_pkg::MAX_RES))
        else $error("bad bundle push");
`endif

endmodule

>>> hdl/tsvt_queue.sv
// Short queue of result bundles between tokenizer front and back end.
// Depends on tsvt_pkg.
`timescale 1ns / 1ps

module tsvt_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tsvt_pkg::t_bundle i_data,
    input  logic              i_pop,
    output tsvt_pkg::t_bundle o_head,
    output logic              o_full,
    output logic              o_empty
);

    tsvt_pkg::t_bundle                 r_mem [tsvt_pkg::QDEPTH];
    logic [tsvt_pkg::QPTR_W-1:0]       r_wr_ptr;
    logic [tsvt_pkg::QPTR_W-1:0]       r_rd_ptr;
    logic [tsvt_pkg::QCNT_W-1:0]       r_count;

    assign o_full  = (r_count == tsvt_pkg::QCNT_W'(tsvt_pkg::QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + tsvt_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + tsvt_pkg::QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + tsvt_pkg::QCNT_W'(1);
                2'b01:   r_count <= r_count - tsvt_pkg::QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= tsvt_pkg::QCNT_W'(tsvt_pkg::QDEPTH))
        else $error("queue count out of range");
`endif

endmodule

>>> hdl/tsvt_back.sv
// Back end of the TSV tokenizer: walks the head bundle one result per
// cycle into the output register while it is free. Depends on tsvt_pkg.
`timescale 1ns / 1ps

module tsvt_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tsvt_pkg::t_bundle   i_head,
    input  logic                i_empty,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tsvt_pkg::t_out_item o_out_data
);

    logic [tsvt_pkg::RCNT_W-1:0] r_idx;
    logic [tsvt_pkg::RCNT_W-1:0] n_idx;
    logic                        r_valid;
    logic                        n_valid;
    tsvt_pkg::t_out_item         r_out;
    tsvt_pkg::t_out_item         n_out;
    logic                        load;
    logic                        last;

    // output register free for a new result
    assign load = !r_valid || i_out_ready;
    assign last = (r_idx == i_head.count - tsvt_pkg::RCNT_W'(1));

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        n_out   = r_out;
        o_pop   = 1'b0;
        if (load) begin
            n_valid = !i_empty;
            if (!i_empty) begin
                n_out = i_head.items[r_idx[$clog2(tsvt_pkg::MAX_RES)-1:0]];
                if (last) begin
                    o_pop = 1'b1;
                    n_idx = '0;
                end else begin
                    n_idx = r_idx + tsvt_pkg::RCNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_idx_in_bundle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> r_idx < i_head.count)
        else $error("result index past bundle end");
    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_empty |-> r_idx == '0)
        else $error("result index left over with empty queue");
    a_pop_marks_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> o_out_valid && o_out_data.last_of_run)
        else $error("bundle retired without last-of-run result");
`endif

endmodule

>>> test/tsv_record_tokenizer_tb.sv
// Testbench for tsv_record_tokenizer: streams text buffers through the byte channel and
// checks every tagged result against a cycle-free tokenizer predictor kept in the bench.
// Depends on tsvt_pkg and hdl/tsv_record_tokenizer.sv.
`timescale 1ns / 1ps

module tsv_record_tokenizer_tb;
    import tsvt_pkg::*;

    localparam int RANDOM_BYTES = 280;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PRINT_CAP    = 40;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    t_in_item  byte_queue [$];
    t_out_item tag_expect [$];
    t_out_item step_tags  [$];

    // Predictor state
    t_phase tk_phase   = PH_SKIP;
    logic   tk_cr_held = 1'b0;
    int     tk_fields  = 0;
    logic   tk_first   = 1'b0;
    logic   tk_whole   = 1'b0;

    int   cycle_cnt    = 0;
    int   errors       = 0;
    int   bytes_sent   = 0;
    int   tags_checked = 0;
    int   overflows    = 0;
    int   records      = 0;
    logic in_fire      = 1'b0;

    int burst_left = 1;
    int gap_left   = 0;
    int rx_mode    = 0;
    int rx_left    = 0;

    tsv_record_tokenizer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= PRINT_CAP) $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    endtask

    function automatic void tag_add(input logic [2:0] kind, input logic [7:0] data);
        t_out_item t;
        if (step_tags.size() >= MAX_RES) return;
        t.kind        = kind;
        t.data_byte   = data;
        t.last_of_run = 1'b0;
        step_tags.push_back(t);
    endfunction

    function automatic void tk_clear();
        tk_phase   = PH_SKIP;
        tk_cr_held = 1'b0;
        tk_fields  = 0;
        tk_first   = 1'b0;
        tk_whole   = 1'b0;
    endfunction

    function automatic void close_record();
        tag_add(K_END, 8'h00);
        records++;
        tk_phase  = PH_SKIP;
        tk_fields = 0;
        tk_first  = 1'b0;
        tk_whole  = 1'b0;
    endfunction

    function automatic void open_field();
        if (tk_fields >= FIELD_LIMIT) begin
            tag_add(K_OVERFLOW, 8'h00);
            overflows++;
            tk_phase = PH_DEAD;
            return;
        end
        tk_fields++;
        tag_add(K_FIELD, 8'h00);
        tk_phase = PH_KEY;
        tk_first = 1'b1;
        tk_whole = 1'b0;
    endfunction

    function automatic logic line_open();
        return tk_phase == PH_TYPE || tk_phase == PH_KEY || tk_phase == PH_VALUE;
    endfunction

    // Advance the line parser by one (already unheld) character
    function automatic void tag_char(input logic [7:0] b);
        case (tk_phase)
            PH_SKIP: begin
                if (b == CH_HASH) begin
                    tk_phase = PH_COMMENT;
                end else if (b != CH_SPACE && b != CH_TAB && b != CH_LF) begin
                    tk_phase = PH_TYPE;
                    tag_add(K_TYPE, b);
                end
            end
            PH_COMMENT: begin
                if (b == CH_LF) tk_phase = PH_SKIP;
            end
            PH_TYPE, PH_VALUE: begin
                if (b == CH_TAB) open_field();
                else if (b == CH_LF) close_record();
                else tag_add((tk_phase == PH_TYPE) ? K_TYPE : K_VALUE, b);
            end
            PH_KEY: begin
                if (b == CH_TAB) begin
                    open_field();
                end else if (b == CH_LF) begin
                    close_record();
                end else if (b == CH_EQ && !tk_first && !tk_whole) begin
                    tk_phase = PH_VALUE;
                end else begin
                    // leading '=' makes the whole token a key
                    if (b == CH_EQ && tk_first) tk_whole = 1'b1;
                    tk_first = 1'b0;
                    tag_add(K_KEY, b);
                end
            end
            default: begin
            end
        endcase
    endfunction

    // Work out every tagged result caused by one accepted byte
    function automatic void tag_byte(input t_in_item it);
        logic [7:0] b;
        b = it.byte_in;
        step_tags.delete();
        if (tk_cr_held) begin
            tk_cr_held = 1'b0;
            if (b != CH_LF) tag_char(CH_CR);
        end
        if (b == CH_CR && (tk_phase == PH_SKIP || line_open())) begin
            if (!it.end_of_buffer) tk_cr_held = 1'b1;
        end else begin
            tag_char(b);
        end
        if (it.end_of_buffer) begin
            if (line_open()) close_record();
            tk_clear();
        end
        if (step_tags.size() != 0) step_tags[step_tags.size() - 1].last_of_run = 1'b1;
        foreach (step_tags[i]) tag_expect.push_back(step_tags[i]);
    endfunction

    function automatic void queue_buffer(input logic [7:0] text [$]);
        t_in_item it;
        foreach (text[i]) begin
            it.byte_in       = text[i];
            it.end_of_buffer = (i == text.size() - 1);
            byte_queue.push_back(it);
        end
    endfunction

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 8'($urandom_range(8'h61, 8'h7A));
        if (r < 70) return CH_EQ;
        if (r < 76) return CH_SPACE;
        if (r < 80) return CH_HASH;
        if (r < 84) return CH_CR;
        return 8'($urandom_range(0, 255));
    endfunction

    // Monitor: predict on byte transfers, check result transfers
    always @(posedge clk) begin
        t_out_item want;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        in_fire = 1'b0;
        if (rst_n && in_valid && in_ready) begin
            in_fire = 1'b1;
            bytes_sent++;
            tag_byte(in_data);
        end
        if (rst_n && out_valid && out_ready) begin
            if (tag_expect.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d data %02h last %0b",
                                          out_data.kind, out_data.data_byte,
                                          out_data.last_of_run));
            end else begin
                want = tag_expect.pop_front();
                tags_checked++;
                if (out_data.kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", out_data.kind, want.kind));
                if (out_data.data_byte !== want.data_byte)
                    report_mismatch($sformatf("data_byte %02h, want %02h",
                                              out_data.data_byte, want.data_byte));
                if (out_data.last_of_run !== want.last_of_run)
                    report_mismatch($sformatf("last_of_run %0b, want %0b",
                                              out_data.last_of_run, want.last_of_run));
            end
        end
    end

    // Driver: bursts of bytes with random gaps
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !in_fire) begin
            // hold until the transfer
        end else if (gap_left > 0) begin
            in_valid <= 1'b0;
            gap_left--;
        end else if (byte_queue.size() != 0) begin
            in_data  <= byte_queue.pop_front();
            in_valid <= 1'b1;
            if (burst_left > 1) begin
                burst_left--;
            end else if ($urandom_range(0, 5) == 0) begin
                burst_left = $urandom_range(30, 60);
                gap_left   = 0;
            end else begin
                burst_left = $urandom_range(1, 12);
                gap_left   = $urandom_range(1, 6);
            end
        end else begin
            in_valid <= 1'b0;
        end
    end

    // Receiver: runs of ready, random chatter and solid stalls
    always @(negedge clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_left = (rx_mode == 2) ? $urandom_range(1, 10) : $urandom_range(5, 40);
        end
        rx_left--;
        case (rx_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= 1'b0;
        endcase
    end

    initial begin
        logic [7:0] dir_text  [$];
        logic [7:0] line_text [$];
        int         lines_n;
        int         nf;
        int         r;
        logic       wide_line;

        // Comment line, blank line, a record with key=value, all-key "=a=" and CR before LF;
        // then a leading CR as type byte, extreme bytes, a key with no '=', a value holding
        // '=', and a CR that ends the buffer.
        dir_text = '{CH_HASH, "c", CH_LF,
                     CH_SPACE, CH_LF,
                     "T", CH_TAB, "k", CH_EQ, "v", CH_TAB, CH_EQ, "a", CH_EQ, CH_CR, CH_LF,
                     CH_CR, 8'h00, CH_TAB, "n", CH_TAB, "p", CH_EQ, "q", CH_EQ, 8'hFF, CH_CR};
        queue_buffer(dir_text);

        while (byte_queue.size() < dir_text.size() + RANDOM_BYTES) begin
            line_text.delete();
            lines_n = $urandom_range(1, 4);
            for (int ln = 0; ln < lines_n; ln++) begin
                repeat ($urandom_range(0, 2))
                    line_text.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    line_text.push_back(CH_HASH);
                    repeat ($urandom_range(0, 4)) line_text.push_back(pick_char());
                end else if (r >= 18) begin
                    line_text.push_back(8'($urandom_range(8'h41, 8'h5A)));
                    repeat ($urandom_range(0, 2)) line_text.push_back(pick_char());
                    wide_line = ($urandom_range(0, 7) == 0);
                    nf = wide_line ? $urandom_range(FIELD_LIMIT - 1, FIELD_LIMIT + 2)
                                   : $urandom_range(0, 4);
                    for (int f = 0; f < nf; f++) begin
                        line_text.push_back(CH_TAB);
                        if (wide_line) begin
                            if ($urandom_range(0, 1)) line_text.push_back(pick_char());
                        end else begin
                            if ($urandom_range(0, 5) == 0) line_text.push_back(CH_EQ);
                            repeat ($urandom_range(0, 3)) line_text.push_back(pick_char());
                            if ($urandom_range(0, 3) != 0) line_text.push_back(CH_EQ);
                            repeat ($urandom_range(0, 3)) line_text.push_back(pick_char());
                        end
                    end
                end
                if ($urandom_range(0, 3) == 0) line_text.push_back(CH_CR);
                if (ln < lines_n - 1 || $urandom_range(0, 1)) line_text.push_back(CH_LF);
            end
            if (line_text.size() == 0) line_text.push_back(pick_char());
            queue_buffer(line_text);
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (byte_queue.size() != 0 || in_valid) @(posedge clk);
        while (tag_expect.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run sent %0d bytes in %0d cycles and checked %0d tagged results,",
                 bytes_sent, cycle_cnt, tags_checked);
        $display("closing %0d records and reporting %0d field overflows; %0d mismatches.",
                 records, overflows, errors);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/tsvt_pkg.sv
hdl/tsvt_front.sv
hdl/tsvt_queue.sv
hdl/tsvt_back.sv
hdl/tsv_record_tokenizer.sv
test/tsv_record_tokenizer_tb.sv
